### rtl/ctab_pkg.sv
// ============================================================================
// ctab_pkg: shared types and constants for the card ID table
// Operation codes, result codes, sequencer states and the scan status
// bundle that passes between the scan unit and the sequencer.
// ============================================================================
package ctab_pkg;

    localparam int KIND_W   = 2;
    localparam int ID_W     = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;

    // An empty slot holds all ones.
    localparam logic [ID_W-1:0] EMPTY_ID = {ID_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        OP_VERIFY = 2'd0,
        OP_ADD    = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_ROOM   = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_RESP
    } state_t;

    typedef struct packed {
        logic hit;
        logic free_avail;
    } scan_t;

endpackage

### rtl/ctab_req_if.sv
// ============================================================================
// ctab_req_if: request channel of the card ID table
// Carries one operation and one card ID per beat.
// ============================================================================
interface ctab_req_if
    import ctab_pkg::*;
();

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   card_id;

    modport source (output valid, output kind, output card_id, input ready);
    modport sink   (input valid, input kind, input card_id, output ready);

endinterface

### rtl/ctab_rsp_if.sv
// ============================================================================
// ctab_rsp_if: response channel of the card ID table
// Carries the status and slot index of one operation per beat.
// ============================================================================
interface ctab_rsp_if
    import ctab_pkg::*;
();

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                slot_valid;

    modport source (output valid, output status, output slot, output slot_valid,
                    input ready);
    modport sink   (input valid, input status, input slot, input slot_valid,
                    output ready);

endinterface

### rtl/ctab_ram.sv
// ============================================================================
// ctab_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module ctab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/ctab_scan.sv
// ============================================================================
// ctab_scan: shared compare unit of the card ID table
// Compares one slot per cycle against the key and remembers the lowest
// empty slot seen since the walk started.
// ============================================================================
module ctab_scan
    import ctab_pkg::*;
#(
    parameter int IDX_W = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [ID_W-1:0]  key,
    input  logic [ID_W-1:0]  entry,
    input  logic             entry_valid,
    input  logic             cmp_pend,
    input  logic [IDX_W-1:0] cmp_idx,
    output scan_t            res,
    output logic [IDX_W-1:0] free_idx
);

    logic             free_found_reg;
    logic             free_found_next;
    logic [IDX_W-1:0] free_idx_reg;
    logic [IDX_W-1:0] free_idx_next;
    logic [ID_W-1:0]  eff_entry;
    logic             cur_free;

    // A slot that was never filled, or was emptied, reads as all ones.
    assign eff_entry      = entry_valid ? entry : EMPTY_ID;
    assign cur_free       = cmp_pend && !entry_valid;
    assign res.hit        = cmp_pend && (eff_entry == key);
    assign res.free_avail = free_found_reg || cur_free;
    assign free_idx       = free_found_reg ? free_idx_reg : cmp_idx;

    always_comb
    begin
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        if (start)
        begin
            free_found_next = 1'b0;
        end
        else if (cur_free && !free_found_reg)
        begin
            free_found_next = 1'b1;
            free_idx_next   = cmp_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_found_reg <= 1'b0;
        end
        else
        begin
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_idx_reg <= free_idx_next;
    end

endmodule

### rtl/card_id_table_core.sv
// ============================================================================
// card_id_table_core: content-searched table of card IDs
// Verify, add, delete and clear over a table of SLOTS 32-bit card IDs.
// ============================================================================
// Each request beat is worked through alone. Clear skips the walk: the
// sequencer goes from idle straight to the response state. Verify, add and
// delete walk the table from slot 0 upward, one slot per cycle through the
// RAM read port and a single comparator, and stop at the first match.
// Request ready is high only while the sequencer is idle. A finished
// response sits in an output register, so a new request is taken while
// the previous response beat is still pending. No clearing pass follows
// reset: per-slot valid flops mark empty slots.
module card_id_table_core
    import ctab_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    ctab_req_if.sink   req,
    ctab_rsp_if.source rsp
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] SLOT_CNT = CNT_W'(SLOTS);

    state_t              state_reg;
    state_t              state_next;
    op_kind_t            op_reg;
    op_kind_t            op_next;
    logic [ID_W-1:0]     key_reg;
    logic [ID_W-1:0]     key_next;
    logic [CNT_W-1:0]    rd_cnt_reg;
    logic [CNT_W-1:0]    rd_cnt_next;
    logic                cmp_pend_reg;
    logic                cmp_pend_next;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic [IDX_W-1:0]    cmp_idx_next;
    logic [SLOTS-1:0]    valid_bits_reg;
    logic [SLOTS-1:0]    valid_bits_next;
    status_t             res_status_reg;
    status_t             res_status_next;
    logic [IDX_W-1:0]    res_idx_reg;
    logic [IDX_W-1:0]    res_idx_next;
    logic                res_hit_reg;
    logic                res_hit_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    status_t             out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic                out_slot_valid_reg;

    logic                accept;
    logic                out_load;
    logic                decide;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [ID_W-1:0]     rd_data;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    scan_t               scan;
    logic [IDX_W-1:0]    free_idx;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_load  = (state_reg == S_RESP) && (!out_valid_reg || rsp.ready);
    assign rd_en     = (state_reg == S_WALK) && (rd_cnt_reg < SLOT_CNT);
    assign rd_addr   = rd_cnt_reg[IDX_W-1:0];

    // The walk ends on the first hit or once the last slot has been compared.
    assign decide = (state_reg == S_WALK)
                  && (scan.hit || (cmp_pend_reg && (cmp_idx_reg == LAST_IDX)));

    ctab_ram #(
        .WIDTH (ID_W),
        .DEPTH (SLOTS),
        .AW    (IDX_W)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (key_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ctab_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept),
        .key         (key_reg),
        .entry       (rd_data),
        .entry_valid (valid_bits_reg[cmp_idx_reg]),
        .cmp_pend    (cmp_pend_reg),
        .cmp_idx     (cmp_idx_reg),
        .res         (scan),
        .free_idx    (free_idx)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (op_kind_t'(req.kind) == OP_CLEAR) ? S_RESP : S_WALK;
                end
            end
            S_WALK:
            begin
                if (decide)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next         = op_reg;
        key_next        = key_reg;
        rd_cnt_next     = rd_cnt_reg;
        cmp_pend_next   = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        valid_bits_next = valid_bits_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_hit_next    = res_hit_reg;
        wr_en           = 1'b0;
        wr_addr         = free_idx;

        if (accept)
        begin
            op_next         = op_kind_t'(req.kind);
            key_next        = req.card_id;
            rd_cnt_next     = '0;
            res_status_next = ST_OK;
            res_idx_next    = '0;
            res_hit_next    = 1'b0;
            if (op_kind_t'(req.kind) == OP_CLEAR)
            begin
                valid_bits_next = '0;
            end
        end

        if (rd_en)
        begin
            rd_cnt_next   = rd_cnt_reg + CNT_W'(1);
            cmp_pend_next = 1'b1;
            cmp_idx_next  = rd_addr;
        end

        if (decide)
        begin
            cmp_pend_next = 1'b0;
            if (scan.hit)
            begin
                res_status_next = ST_OK;
                res_idx_next    = cmp_idx_reg;
                res_hit_next    = 1'b1;
                if (op_reg == OP_DELETE)
                begin
                    valid_bits_next[cmp_idx_reg] = 1'b0;
                end
            end
            else
            begin
                case (op_reg)
                    OP_ADD:
                    begin
                        if (scan.free_avail)
                        begin
                            wr_en                     = 1'b1;
                            valid_bits_next[free_idx] = 1'b1;
                            res_status_next           = ST_OK;
                            res_idx_next              = free_idx;
                            res_hit_next              = 1'b1;
                        end
                        else
                        begin
                            res_status_next = ST_NO_ROOM;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_NOT_FOUND;
                    end
                endcase
            end
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmp_pend_reg   <= 1'b0;
            valid_bits_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cmp_pend_reg   <= cmp_pend_next;
            valid_bits_reg <= valid_bits_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        rd_cnt_reg     <= rd_cnt_next;
        cmp_idx_reg    <= cmp_idx_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_hit_reg    <= res_hit_next;
        if (out_load)
        begin
            out_status_reg     <= res_status_reg;
            out_slot_reg       <= res_hit_reg ? SLOT_W'(res_idx_reg) : '0;
            out_slot_valid_reg <= res_hit_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.slot       = out_slot_reg;
    assign rsp.slot_valid = out_slot_valid_reg;

`ifndef SYNTH
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("sequencer stayed idle after a request beat");

    a_clear_empties_all: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op_kind_t'(req.kind) == OP_CLEAR)) |=> (valid_bits_reg == '0))
        else $error("clear left a slot marked as filled");

    a_compare_only_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_pend_reg |-> (state_reg == S_WALK))
        else $error("slot compare pending outside a walk");

    a_slot_valid_means_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.slot_valid) |-> (rsp.status == ST_OK))
        else $error("slot index reported with an error status");

    a_no_index_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.slot_valid) |-> (rsp.slot == '0))
        else $error("slot not zero on a beat without an index");
`endif

endmodule

### tb/sv/tb_card_id_table_core.sv
// ============================================================================
// tb_card_id_table_core: self-checking testbench for the card ID table
// A queue-fed driver sends verify, add, delete and clear requests in bursts
// with random gaps. A shadow table predicts status, slot and slot_valid for
// every accepted request. A monitor with its own stall pattern checks each
// response beat against the oldest prediction.
// ============================================================================
module tb_card_id_table_core;

    timeunit 1ns;
    timeprecision 1ps;

    import ctab_pkg::*;

    localparam int TABLE_SLOTS  = 16;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int CHUNKS       = 16;
    localparam int CHUNK_ITEMS  = 100;
    localparam int POOL_MAX     = 24;

    typedef struct packed {
        op_kind_t        kind;
        logic [ID_W-1:0] card_id;
    } card_req_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic              slot_valid;
    } card_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    ctab_req_if req_ch ();
    ctab_rsp_if rsp_ch ();

    card_id_table_core #(
        .SLOTS (TABLE_SLOTS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    card_req_t       pending_reqs[$];
    card_rsp_t       expected_rsps[$];
    logic [ID_W-1:0] shadow_ids[TABLE_SLOTS];
    int              errors      = 0;
    int              idle_cycles = 0;
    int              gap_left;
    int              burst_left;
    int              stall_left;
    logic [8:0]      rsp_phase;

    // Lowest slot whose stored ID equals key, or -1.
    function automatic int lowest_match(logic [ID_W-1:0] key);
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            if (shadow_ids[i] == key)
                return i;
        end
        return -1;
    endfunction

    // Applies one operation to the shadow table and returns its response.
    function automatic card_rsp_t apply_table_op(op_kind_t op, logic [ID_W-1:0] id);
        card_rsp_t r;
        int        hit;
        int        free_slot;
        r.status     = ST_OK;
        r.slot       = '0;
        r.slot_valid = 1'b0;
        hit          = lowest_match(id);
        case (op)
            OP_VERIFY:
            begin
                if (hit >= 0)
                begin
                    r.slot       = hit[SLOT_W-1:0];
                    r.slot_valid = 1'b1;
                end
                else
                    r.status = ST_NOT_FOUND;
            end
            OP_ADD:
            begin
                if (hit >= 0)
                begin
                    r.slot       = hit[SLOT_W-1:0];
                    r.slot_valid = 1'b1;
                end
                else
                begin
                    free_slot = lowest_match(EMPTY_ID);
                    if (free_slot >= 0)
                    begin
                        shadow_ids[free_slot] = id;
                        r.slot                = free_slot[SLOT_W-1:0];
                        r.slot_valid          = 1'b1;
                    end
                    else
                        r.status = ST_NO_ROOM;
                end
            end
            OP_DELETE:
            begin
                if (hit >= 0)
                begin
                    shadow_ids[hit] = EMPTY_ID;
                    r.slot          = hit[SLOT_W-1:0];
                    r.slot_valid    = 1'b1;
                end
                else
                    r.status = ST_NOT_FOUND;
            end
            default:
            begin
                for (int i = 0; i < TABLE_SLOTS; i++)
                    shadow_ids[i] = EMPTY_ID;
            end
        endcase
        return r;
    endfunction

    task automatic queue_req(op_kind_t k, logic [ID_W-1:0] id);
        card_req_t item;
        item.kind    = k;
        item.card_id = id;
        pending_reqs.push_back(item);
    endtask

    // Sampled at the falling edge so that queue and handshake state are settled.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0);
    endtask

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        card_req_t next_req;
        if (!rst_n)
        begin
            req_ch.valid   <= 1'b0;
            req_ch.kind    <= OP_VERIFY;
            req_ch.card_id <= '0;
            gap_left       <= 0;
            burst_left     <= 1;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                expected_rsps.push_back(apply_table_op(op_kind_t'(req_ch.kind),
                                                       req_ch.card_id));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left     <= gap_left - 1;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    next_req       = pending_reqs.pop_front();
                    req_ch.valid   <= 1'b1;
                    req_ch.kind    <= next_req.kind;
                    req_ch.card_id <= next_req.card_id;
                    if (burst_left > 1)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                    end
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Response monitor. The receiver never stalls in the first quarter of
    // each wrap of the 9-bit phase counter and stalls at random for the rest.
    always @(posedge clk or negedge rst_n)
    begin
        card_rsp_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
            rsp_phase    <= '0;
        end
        else
        begin
            rsp_phase <= rsp_phase + 1'b1;
            if (rsp_phase[8:7] == 2'd0)
                rsp_ch.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left   <= stall_left - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                stall_left   <= $urandom_range(0, 15);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;

            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: response beat with none expected, status %0d slot %0d valid %0b",
                             $time, rsp_ch.status, rsp_ch.slot, rsp_ch.slot_valid);
                    errors++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp_ch.status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, rsp_ch.status);
                        errors++;
                    end
                    if (rsp_ch.slot !== want.slot)
                    begin
                        $display("%0t: slot mismatch, expected %0d, actual %0d",
                                 $time, want.slot, rsp_ch.slot);
                        errors++;
                    end
                    if (rsp_ch.slot_valid !== want.slot_valid)
                    begin
                        $display("%0t: slot_valid mismatch, expected %0b, actual %0b",
                                 $time, want.slot_valid, rsp_ch.slot_valid);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("%0t: no beat on either channel for %0d cycles", $time, IDLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        logic [ID_W-1:0] id_pool[POOL_MAX];
        int              pool_n;
        int              pick;
        logic [ID_W-1:0] key;
        op_kind_t        op;

        for (int i = 0; i < TABLE_SLOTS; i++)
            shadow_ids[i] = EMPTY_ID;

        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. An all-ones key matches the lowest empty slot.
        queue_req(OP_VERIFY, 32'h0000_0000);
        queue_req(OP_VERIFY, EMPTY_ID);
        queue_req(OP_ADD,    EMPTY_ID);
        queue_req(OP_DELETE, EMPTY_ID);
        queue_req(OP_ADD,    32'h0000_0000);
        queue_req(OP_ADD,    32'hFFFF_FFFE);
        queue_req(OP_ADD,    32'h0000_0000);
        queue_req(OP_DELETE, 32'h0000_0000);
        queue_req(OP_DELETE, 32'h0000_0000);
        // Refill slot 0 and then slots 2 to 15 until the table is full.
        for (int i = 0; i < TABLE_SLOTS - 1; i++)
            queue_req(OP_ADD, 32'hA5A5_0000 | i);
        queue_req(OP_ADD,    32'h5A5A_5A5A);
        queue_req(OP_VERIFY, EMPTY_ID);
        queue_req(OP_CLEAR,  32'h1234_5678);
        queue_req(OP_VERIFY, 32'hFFFF_FFFE);
        wait_drained();

        // Random part: IDs mostly come from a small pool so that hits, fills
        // and full-table cases keep recurring; the rest is noise.
        for (int c = 0; c < CHUNKS; c++)
        begin
            pool_n = $urandom_range(4, POOL_MAX);
            for (int i = 0; i < POOL_MAX; i++)
                id_pool[i] = $urandom;
            if ($urandom_range(0, 1) == 0)
                id_pool[0] = 32'h0000_0000;
            if ($urandom_range(0, 1) == 0)
                id_pool[1] = 32'hFFFF_FFFE;
            for (int n = 0; n < CHUNK_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    op = OP_CLEAR;
                else if (pick < 42)
                    op = OP_ADD;
                else if (pick < 70)
                    op = OP_VERIFY;
                else
                    op = OP_DELETE;
                pick = $urandom_range(0, 99);
                if (pick < 85)
                    key = id_pool[$urandom_range(0, pool_n - 1)];
                else if (pick < 90)
                    key = EMPTY_ID;
                else
                    key = $urandom;
                queue_req(op, key);
            end
            // Hold the sender off now and then until every response is in.
            if (c % 4 == 3)
                wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
